>>> hdl/atc_pkg.sv
// ----------------------------------------------------------------------------
// Affine transform composer package
// Types, fixed-point constants and divider tables shared by the composer.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;

    // Reciprocals ceil(2^SH / d) for the Horner divisors; exact for 30-bit dividends.
    localparam logic [30:0] SIN_MUL [SIN_STEPS] = '{
        31'd1249445032, 31'd1908874354, 31'd1636178018, 31'd1717986919, 31'd1431655766
    };
    localparam int SIN_SH [SIN_STEPS] = '{37, 37, 36, 35, 33};

    localparam logic [30:0] COS_MUL [COS_STEPS] = '{
        31'd2082408386, 31'd1527099484, 31'd1227133514,
        31'd1145324613, 31'd1431655766, 31'd1073741824
    };
    localparam int COS_SH [COS_STEPS] = '{38, 37, 36, 35, 34, 31};

    localparam int SC_LAT  = 16;
    localparam int MAT_LAT = 6;
    localparam int LAT     = SC_LAT + MAT_LAT;

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic [15:0]        angle_x;
        logic [15:0]        angle_y;
        logic [15:0]        angle_z;
        logic signed [31:0] scale_factor;
    } pose_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m03;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m13;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m23;
    } mat_t;

    typedef struct packed {
        logic signed [31:0] sn;
        logic signed [31:0] cs;
    } trig_t;

    typedef logic [8:0][31:0] rot_t;

endpackage

>>> hdl/atc_if.sv
// ----------------------------------------------------------------------------
// Affine transform composer channels
// Valid/ready channels for pose beats and matrix beats.
// ----------------------------------------------------------------------------
interface atc_pose_if;
    logic           valid;
    logic           ready;
    atc_pkg::pose_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface atc_mat_if;
    logic          valid;
    logic          ready;
    atc_pkg::mat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/atc_horner_cell.sv
// ----------------------------------------------------------------------------
// Horner cell
// One series step p' = 1 - (x2 * p) / d in unsigned Q30, over two stages.
// ----------------------------------------------------------------------------
module atc_horner_cell #(
    parameter logic [30:0] MUL = 31'd1431655766,
    parameter int          SH  = 33
) (
    input  logic        clk,
    input  logic        en,
    input  logic [29:0] x2,
    input  logic [30:0] p_in,
    output logic [30:0] p_out
);
    import atc_pkg::*;

    logic [60:0] xp;
    logic [60:0] qm;
    logic [29:0] q_next;
    logic [29:0] q_reg;
    logic [30:0] p_next;
    logic [30:0] p_reg;

    assign xp     = 61'(x2) * 61'(p_in);
    assign q_next = xp[59:30];
    assign qm     = 61'(q_reg) * 61'(MUL);
    assign p_next = Q30_ONE - 31'(qm >> SH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
            p_reg <= p_next;
        end
    end

    assign p_out = p_reg;

endmodule

>>> hdl/atc_sincos.sv
// ----------------------------------------------------------------------------
// Sine and cosine unit
// Octant fold, series evaluation through a sine row and a cosine row of Horner cells, quadrant fixup.
// ----------------------------------------------------------------------------
module atc_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic           clk,
    input  logic           en,
    input  logic [15:0]    angle,
    output atc_pkg::trig_t trig
);
    import atc_pkg::*;

    localparam int          TURN_SHIFT = 32 - ANGLE_BITS;
    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int          QU_DEPTH   = 15;
    localparam int          X_DEPTH    = 12;
    localparam int          X2_DEPTH   = 11;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [31:0] turn;
    logic        upper;
    logic [29:0] t_next;
    logic [29:0] t_reg;
    logic [2:0]  qu_reg [QU_DEPTH];
    logic [62:0] tx_prod;
    logic [59:0] xx_prod;
    logic [29:0] x_reg [X_DEPTH];
    logic [29:0] x2_reg [X2_DEPTH];
    logic [30:0] cos_p [COS_STEPS+1];
    logic [30:0] sin_p [SIN_STEPS+1];
    logic [60:0] sx_prod;
    logic [30:0] sv_next;
    logic [30:0] sv_reg;
    logic [30:0] sv2_reg;
    logic [30:0] sv_c;
    logic [30:0] cv_c;
    logic signed [31:0] a_s;
    logic signed [31:0] b_s;
    trig_t       trig_next;
    trig_t       trig_reg;

    assign turn    = (32'(angle) & ANGLE_MASK) << TURN_SHIFT;
    assign upper   = turn[29];
    assign t_next  = upper ? 30'(Q30_ONE - {1'b0, turn[29:0]}) : turn[29:0];
    assign tx_prod = 63'(t_reg) * 63'(TWO_PI_Q30);
    assign xx_prod = 60'(x_reg[0]) * 60'(x_reg[0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= t_next;
            qu_reg[0] <= {turn[31:30], upper};
            x_reg[0]  <= tx_prod[61:32];
            x2_reg[0] <= xx_prod[59:30];
            for (int i = 1; i < QU_DEPTH; i++)
            begin
                qu_reg[i] <= qu_reg[i-1];
            end
            for (int i = 1; i < X_DEPTH; i++)
            begin
                x_reg[i] <= x_reg[i-1];
            end
            for (int i = 1; i < X2_DEPTH; i++)
            begin
                x2_reg[i] <= x2_reg[i-1];
            end
        end
    end

    assign cos_p[0] = Q30_ONE;
    assign sin_p[0] = Q30_ONE;

    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_cos
        atc_horner_cell #(.MUL(COS_MUL[i]), .SH(COS_SH[i])) u_cell (
            .clk   (clk),
            .en    (en),
            .x2    (x2_reg[2*i]),
            .p_in  (cos_p[i]),
            .p_out (cos_p[i+1])
        );
    end

    for (genvar i = 0; i < SIN_STEPS; i++)
    begin : g_sin
        atc_horner_cell #(.MUL(SIN_MUL[i]), .SH(SIN_SH[i])) u_cell (
            .clk   (clk),
            .en    (en),
            .x2    (x2_reg[2*i]),
            .p_in  (sin_p[i]),
            .p_out (sin_p[i+1])
        );
    end

    assign sx_prod = 61'(x_reg[X_DEPTH-1]) * 61'(sin_p[SIN_STEPS]);
    assign sv_next = sx_prod[60:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg   <= sv_next;
            sv2_reg  <= sv_reg;
            trig_reg <= trig_next;
        end
    end

    always_comb
    begin
        sv_c = (sv2_reg > Q30_ONE) ? Q30_ONE : sv2_reg;
        cv_c = (cos_p[COS_STEPS] > Q30_ONE) ? Q30_ONE : cos_p[COS_STEPS];
        a_s  = qu_reg[QU_DEPTH-1][0] ? signed'({1'b0, cv_c}) : signed'({1'b0, sv_c});
        b_s  = qu_reg[QU_DEPTH-1][0] ? signed'({1'b0, sv_c}) : signed'({1'b0, cv_c});
        case (qu_reg[QU_DEPTH-1][2:1])
            QUAD_0:
            begin
                trig_next.sn = a_s;
                trig_next.cs = b_s;
            end
            QUAD_1:
            begin
                trig_next.sn = b_s;
                trig_next.cs = -a_s;
            end
            QUAD_2:
            begin
                trig_next.sn = -a_s;
                trig_next.cs = -b_s;
            end
            default:
            begin
                trig_next.sn = -b_s;
                trig_next.cs = a_s;
            end
        endcase
    end

    assign trig = trig_reg;

endmodule

>>> hdl/atc_mat.sv
// ----------------------------------------------------------------------------
// Rotation composer
// Forms Rz*Ry, then (Rz*Ry)*Rx, then scales and saturates, over six stages.
// ----------------------------------------------------------------------------
module atc_mat (
    input  logic               clk,
    input  logic               en,
    input  atc_pkg::trig_t     tx,
    input  atc_pkg::trig_t     ty,
    input  atc_pkg::trig_t     tz,
    input  logic signed [31:0] scale,
    output atc_pkg::rot_t      rot
);
    import atc_pkg::*;

    localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN = -36'sh0_8000_0000;

    function automatic logic signed [31:0] rnd64(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v + 64'sd536870912;
        return 32'(s >>> 30);
    endfunction

    function automatic logic signed [33:0] rnd65(input logic signed [64:0] v);
        logic signed [64:0] s;
        s = v + 65'sd536870912;
        return 34'(s >>> 30);
    endfunction

    logic signed [63:0] pc_reg [4];
    logic signed [31:0] sz1_reg, cz1_reg, sy1_reg, cy1_reg, sx1_reg, cx1_reg;
    logic signed [31:0] rzy_next [3][3];
    logic signed [31:0] rzy_reg [3][3];
    logic signed [31:0] sx2_reg, cx2_reg;
    logic signed [63:0] pr_reg [3][4];
    logic signed [31:0] r0_reg [3];
    logic signed [33:0] r_reg [9];
    logic signed [65:0] ps_reg [9];
    logic signed [35:0] v [9];
    logic signed [31:0] m_next [9];
    logic signed [31:0] m_reg [9];

    always_comb
    begin
        rzy_next[0][0] = rnd64(pc_reg[0]);
        rzy_next[0][1] = -sz1_reg;
        rzy_next[0][2] = rnd64(pc_reg[1]);
        rzy_next[1][0] = rnd64(pc_reg[2]);
        rzy_next[1][1] = cz1_reg;
        rzy_next[1][2] = rnd64(pc_reg[3]);
        rzy_next[2][0] = -sy1_reg;
        rzy_next[2][1] = 32'sd0;
        rzy_next[2][2] = cy1_reg;
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            v[k] = 36'((ps_reg[k] + 66'sd536870912) >>> 30);
            if (v[k] > SAT_MAX)
            begin
                m_next[k] = 32'(SAT_MAX);
            end
            else if (v[k] < SAT_MIN)
            begin
                m_next[k] = 32'(SAT_MIN);
            end
            else
            begin
                m_next[k] = 32'(v[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_reg[0] <= 64'(tz.cs) * 64'(ty.cs);
            pc_reg[1] <= 64'(tz.cs) * 64'(ty.sn);
            pc_reg[2] <= 64'(tz.sn) * 64'(ty.cs);
            pc_reg[3] <= 64'(tz.sn) * 64'(ty.sn);
            sz1_reg   <= tz.sn;
            cz1_reg   <= tz.cs;
            sy1_reg   <= ty.sn;
            cy1_reg   <= ty.cs;
            sx1_reg   <= tx.sn;
            cx1_reg   <= tx.cs;
            rzy_reg   <= rzy_next;
            sx2_reg   <= sx1_reg;
            cx2_reg   <= cx1_reg;
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i][0] <= 64'(rzy_reg[i][1]) * 64'(cx2_reg);
                pr_reg[i][1] <= 64'(rzy_reg[i][2]) * 64'(sx2_reg);
                pr_reg[i][2] <= 64'(rzy_reg[i][1]) * 64'(sx2_reg);
                pr_reg[i][3] <= 64'(rzy_reg[i][2]) * 64'(cx2_reg);
                r0_reg[i]    <= rzy_reg[i][0];
                r_reg[i*3]   <= 34'(r0_reg[i]);
                r_reg[i*3+1] <= rnd65(65'(pr_reg[i][0]) + 65'(pr_reg[i][1]));
                r_reg[i*3+2] <= rnd65(65'(pr_reg[i][3]) - 65'(pr_reg[i][2]));
            end
            for (int k = 0; k < 9; k++)
            begin
                ps_reg[k] <= 66'(r_reg[k]) * 66'(scale);
                m_reg[k]  <= m_next[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            rot[k] = m_reg[k];
        end
    end

endmodule

>>> hdl/affine_transform_composer.sv
// Throughput: one pose beat per cycle; the whole pipeline holds while a matrix beat waits.
// Depth is the sine/cosine units, with six two-stage cosine cells, plus six matrix stages.
// Reset clears the pipeline valid bits only; data stages keep whatever they hold.
// ----------------------------------------------------------------------------
// Affine transform composer
// Builds the 3x4 matrix T*Rz*Ry*Rx*S from a pose beat in a fully pipelined datapath.
// ----------------------------------------------------------------------------
module affine_transform_composer #(
    parameter int ANGLE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    atc_pose_if.sink   pose,
    atc_mat_if.source  matrix
);
    import atc_pkg::*;

    localparam int SCL_DEPTH = SC_LAT + 4;

    logic               en;
    logic [LAT-1:0]     vld_next;
    logic [LAT-1:0]     vld_reg;
    logic signed [31:0] tx_reg [LAT];
    logic signed [31:0] ty_reg [LAT];
    logic signed [31:0] tz_reg [LAT];
    logic signed [31:0] scl_reg [SCL_DEPTH];
    trig_t              trig_x;
    trig_t              trig_y;
    trig_t              trig_z;
    rot_t               rot;

    assign en         = !vld_reg[LAT-1] || matrix.ready;
    assign pose.ready = en;
    assign vld_next   = {vld_reg[LAT-2:0], pose.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg[0]  <= pose.data.trans_x;
            ty_reg[0]  <= pose.data.trans_y;
            tz_reg[0]  <= pose.data.trans_z;
            scl_reg[0] <= pose.data.scale_factor;
            for (int i = 1; i < LAT; i++)
            begin
                tx_reg[i] <= tx_reg[i-1];
                ty_reg[i] <= ty_reg[i-1];
                tz_reg[i] <= tz_reg[i-1];
            end
            for (int i = 1; i < SCL_DEPTH; i++)
            begin
                scl_reg[i] <= scl_reg[i-1];
            end
        end
    end

    atc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_x (
        .clk   (clk),
        .en    (en),
        .angle (pose.data.angle_x),
        .trig  (trig_x)
    );

    atc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_y (
        .clk   (clk),
        .en    (en),
        .angle (pose.data.angle_y),
        .trig  (trig_y)
    );

    atc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_z (
        .clk   (clk),
        .en    (en),
        .angle (pose.data.angle_z),
        .trig  (trig_z)
    );

    atc_mat u_mat (
        .clk   (clk),
        .en    (en),
        .tx    (trig_x),
        .ty    (trig_y),
        .tz    (trig_z),
        .scale (scl_reg[SCL_DEPTH-1]),
        .rot   (rot)
    );

    assign matrix.valid    = vld_reg[LAT-1];
    assign matrix.data.m00 = rot[0];
    assign matrix.data.m01 = rot[1];
    assign matrix.data.m02 = rot[2];
    assign matrix.data.m03 = tx_reg[LAT-1];
    assign matrix.data.m10 = rot[3];
    assign matrix.data.m11 = rot[4];
    assign matrix.data.m12 = rot[5];
    assign matrix.data.m13 = ty_reg[LAT-1];
    assign matrix.data.m20 = rot[6];
    assign matrix.data.m21 = rot[7];
    assign matrix.data.m22 = rot[8];
    assign matrix.data.m23 = tz_reg[LAT-1];

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pose.valid && pose.ready |=> vld_reg[0])
        else $error("accepted pose beat did not enter the pipeline");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        matrix.valid && !matrix.ready |-> !pose.ready)
        else $error("pose beat taken while the output is blocked");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SC_LAT-1] |-> trig_z.sn <= 32'sh4000_0000 && trig_z.sn >= -32'sh4000_0000
            && trig_z.cs <= 32'sh4000_0000 && trig_z.cs >= -32'sh4000_0000)
        else $error("sine or cosine outside the unit range");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Affine transform composer testbench
// Drives random and corner-case poses with random idling on both channels and
// checks every matrix beat against a bit-exact fixed-point model of the block.
// ----------------------------------------------------------------------------
module testbench;
    import atc_pkg::*;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint TWO_PI  = 64'sd6746518852;
    localparam int     ANGLE_W = 16;
    localparam int     RANDOM_POSES = 1530;

    logic clk;
    logic rst_n;

    atc_pose_if pose_ch ();
    atc_mat_if  mat_ch ();

    affine_transform_composer #(.ANGLE_BITS(ANGLE_W)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .pose(pose_ch.sink),
        .matrix(mat_ch.source)
    );

    pose_t pending_poses[$];
    mat_t  expected_matrices[$];
    int    mismatch_count;
    bit    stimulus_done;
    bit    idling_enabled;
    int    send_gap;
    int    recv_gap;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    task automatic sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
        longint unsigned turn, r, t, x, x2, p, sv, cv, a, b;
        longint unsigned sdiv[5];
        longint unsigned cdiv[6];
        logic [1:0] quad;
        bit upper;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        turn = {32'd0, ang[ANGLE_W-1:0], {(32-ANGLE_W){1'b0}}};
        quad = turn[31:30];
        r = turn & 64'h3FFF_FFFF;
        upper = r >= (64'd1 << 29);
        t = upper ? (ONE_Q30 - r) : r;
        x = (t * TWO_PI) >> 32;
        x2 = (x * x) >> 30;
        p = ONE_Q30;
        for (int i = 0; i < 5; i++)
            p = ONE_Q30 - ((x2 * p) >> 30) / sdiv[i];
        sv = (x * p) >> 30;
        p = ONE_Q30;
        for (int i = 0; i < 6; i++)
            p = ONE_Q30 - ((x2 * p) >> 30) / cdiv[i];
        cv = p;
        if (sv > ONE_Q30) sv = ONE_Q30;
        if (cv > ONE_Q30) cv = ONE_Q30;
        a = upper ? cv : sv;
        b = upper ? sv : cv;
        case (quad)
            2'd0: begin sn = a;  cs = b;  end
            2'd1: begin sn = b;  cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
    endtask

    function automatic void mul3(input longint a[9], input longint b[9], output longint o[9]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                o[i*3+j] = round_q30(a[i*3]*b[j] + a[i*3+1]*b[3+j] + a[i*3+2]*b[6+j]);
    endfunction

    task automatic compose_matrix(input pose_t p, output mat_t m);
        longint sx, cx, sy, cy, sz, cz, v, scl;
        longint rx[9], ry[9], rz[9], rzy[9], rot[9];
        logic [31:0] ent[9];
        sin_cos(p.angle_x, sx, cx);
        sin_cos(p.angle_y, sy, cy);
        sin_cos(p.angle_z, sz, cz);
        scl = p.scale_factor;
        rx = '{ONE_Q30, 0, 0, 0, cx, -sx, 0, sx, cx};
        ry = '{cy, 0, sy, 0, ONE_Q30, 0, -sy, 0, cy};
        rz = '{cz, -sz, 0, sz, cz, 0, 0, 0, ONE_Q30};
        mul3(rz, ry, rzy);
        mul3(rzy, rx, rot);
        for (int k = 0; k < 9; k++)
        begin
            v = round_q30(rot[k] * scl);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            ent[k] = v[31:0];
        end
        m = '{ent[0], ent[1], ent[2], p.trans_x, ent[3], ent[4], ent[5], p.trans_y,
               ent[6], ent[7], ent[8], p.trans_z};
    endtask

    function automatic pose_t random_pose();
        pose_t p;
        p.trans_x = $urandom;
        p.trans_y = $urandom;
        p.trans_z = $urandom;
        p.angle_x = 16'($urandom);
        p.angle_y = 16'($urandom);
        p.angle_z = 16'($urandom);
        case ($urandom_range(0, 3))
            0: p.scale_factor = $urandom;
            1: p.scale_factor = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: p.scale_factor = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: p.scale_factor = 32'sh0001_0000;
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            p.angle_x[13:0] = 14'd0;
            p.angle_y[13:0] = 14'd0;
            p.angle_z[13:0] = 14'd0;
        end
        return p;
    endfunction

    initial
    begin
        pose_t p;
        logic [15:0] corner_angles[8];
        logic signed [31:0] corner_scales[6];
        mismatch_count = 0;
        stimulus_done = 1'b0;
        idling_enabled = 1'b1;
        corner_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                          16'h2000, 16'h1FFF, 16'hFFFF, 16'h0001};
        corner_scales = '{32'sh0001_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh0000_0000, -32'sh0001_0000, 32'shFFFF_FFFF};
        for (int i = 0; i < 8; i++)
        begin
            p.trans_x = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            p.trans_y = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            p.trans_z = $urandom;
            p.angle_x = corner_angles[i];
            p.angle_y = corner_angles[(i + 3) % 8];
            p.angle_z = corner_angles[(i + 5) % 8];
            p.scale_factor = corner_scales[i % 6];
            pending_poses.push_back(p);
        end
        for (int i = 0; i < 12; i++)
        begin
            p = random_pose();
            p.angle_x = corner_angles[$urandom_range(0, 7)];
            p.scale_factor = corner_scales[i % 6];
            pending_poses.push_back(p);
        end
        for (int i = 0; i < RANDOM_POSES; i++)
            pending_poses.push_back(random_pose());
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_poses.size() < 200);
        idling_enabled <= 1'b0;
        wait (pending_poses.size() == 0 && stimulus_done);
        wait (expected_matrices.size() == 0);
        repeat (LAT + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("affine_transform_composer: match");
        else
            $display("affine_transform_composer: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("affine_transform_composer: mismatch");
        $finish;
    end

    initial
    begin
        pose_ch.valid = 1'b0;
        pose_ch.data = '0;
        mat_ch.ready = 1'b0;
        send_gap = 0;
        recv_gap = 0;
    end

    always @(posedge clk)
    begin
        mat_t m;
        if (rst_n)
        begin
            if (pose_ch.valid && pose_ch.ready)
            begin
                compose_matrix(pose_ch.data, m);
                expected_matrices.push_back(m);
            end
            if (!pose_ch.valid || pose_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    pose_ch.valid <= 1'b0;
                end
                else if (idling_enabled && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 16);
                    pose_ch.valid <= 1'b0;
                end
                else if (pending_poses.size() > 0)
                begin
                    pose_ch.valid <= 1'b1;
                    pose_ch.data <= pending_poses.pop_front();
                end
                else
                begin
                    pose_ch.valid <= 1'b0;
                    stimulus_done = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        mat_t want;
        if (rst_n)
        begin
            if (mat_ch.valid && mat_ch.ready)
            begin
                if (expected_matrices.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected matrix beat %h", mat_ch.data);
                end
                else
                begin
                    want = expected_matrices.pop_front();
                    if (want !== mat_ch.data)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("matrix beat: expected %h actual %h", want, mat_ch.data);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                mat_ch.ready <= 1'b0;
            end
            else if (idling_enabled && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(0, 16);
                mat_ch.ready <= 1'b0;
            end
            else
                mat_ch.ready <= 1'b1;
        end
    end
endmodule
